/* hw/rtl/five_bar_arm_servo_pulse_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the five-bar servo pulse core
// Clocked property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIVE_BAR_ARM_SERVO_PULSE_CORE_ASSERT_SVH
`define FIVE_BAR_ARM_SERVO_PULSE_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define FBAS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked during reset
`define FBAS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset
`define FBAS_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/fbas_pkg.sv */
// ----------------------------------------------------------------------------
// fbas_pkg
// Types, constants and tables for the five-bar servo pulse core.
// ----------------------------------------------------------------------------
package fbas_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 13;
   localparam int CORDIC_PRESHIFT = 24;
   localparam int ATAN_TAB_LEN    = 24;
   localparam longint PI_Q30      = 64'sd3373259426;

   // Q30 -> angle format shift
   localparam int ASH = 30 - ANGLE_FRAC_BITS;

   localparam int COORD_W = 16;
   localparam int MAG_W   = 17;             // |x1|, |2y|
   localparam int SQ_W    = 18;             // root width
   localparam int SQ_RW   = 2 * SQ_W + 1;   // radicand / remainder width
   localparam int CW      = SQ_W + CORDIC_PRESHIFT + 3;
   localparam int ZW      = ANGLE_FRAC_BITS + 3;
   localparam int VW      = ANGLE_FRAC_BITS + 5;

   localparam longint PI_Q      = (PI_Q30 + (longint'(1) << (ASH - 1))) >>> ASH;
   localparam longint HALF_PI_Q = PI_Q / 2;

   // offset a = round(offset * pi / 2880): (N + D/2) >> ASH, >> 6, then / 45
   localparam int     AQ_NW  = 45;
   localparam int     AQ_N3W = AQ_NW - ASH - 6;
   localparam int     AQ_K   = AQ_N3W + 6;
   localparam longint AQ_M   = ((longint'(1) << AQ_K) + 44) / 45;
   localparam int     AQ_MW  = AQ_K - 4;
   localparam int     AQ_W   = ANGLE_FRAC_BITS + 3;
   localparam longint AQ_HALF = longint'(1440) << ASH;

   // pulse offset q = round(|v| * 2000 / pi) through a reciprocal
   localparam int     DV_MW  = ANGLE_FRAC_BITS + 14;
   localparam int     DV_K   = DV_MW + $clog2(PI_Q);
   localparam longint DV_M   = ((longint'(1) << DV_K) + PI_Q - 1) / PI_Q;
   localparam int     DV_MDW = DV_K - $clog2(PI_Q) + 1;
   localparam int     QW     = 14;
   localparam int     PW     = 16;

   localparam int PULSE_W = 12;
   localparam int PULSE_MAX = 4095;

   localparam int NST = 8 + SQ_W + CORDIC_STEPS;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPACING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_LENGTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_ANGLE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_REACH = 2'd1;
   localparam logic [1:0] ST_POINT = 2'd2;

   localparam longint ATAN_Q30 [ATAN_TAB_LEN] = '{
      843314857, 497837829, 263043837, 133525159,
      67021687, 33543516, 16775851, 8388437,
      4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768,
      16384, 8192, 4096, 2048,
      1024, 512, 256, 128
   };

   typedef struct packed {
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic                      joint_side;
   } req_word_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_us;
      logic [1:0]         status;
   } rsp_word_type;

   function automatic logic signed [ZW-1:0] atan_q(input int idx);
      longint v;
      v = (ATAN_Q30[idx] + (longint'(1) << (ASH - 1))) >>> ASH;
      return ZW'(v);
   endfunction

endpackage

/* hw/rtl/five_bar_arm_servo_pulse_core.sv */
// ----------------------------------------------------------------------------
// five_bar_arm_servo_pulse_core
// Pipeline: prep, r^2 and the reach test, then two 18-step root chains,
//   16 CORDIC steps, offset add, |v| scale, reciprocal multiply and clamp.
// Throughput: one word per cycle; a stall on rsp freezes the whole pipe.
// Reset: synchronous, clears valids and loads register defaults.
// ----------------------------------------------------------------------------
module five_bar_arm_servo_pulse_core
   import fbas_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_word,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // side data carried through prep and root stages
   typedef struct packed {
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      logic             neg;
      logic             plus;
      logic [1:0]       status;
   } sq_side_type;

   // side data carried through CORDIC and tail
   typedef struct packed {
      logic       neg;
      logic       plus;
      logic [1:0] status;
   } cd_side_type;

   // ---------------------------------------------------------------------
   // Configuration registers; always ready
   // ---------------------------------------------------------------------
   logic [15:0] base_ff, base_in;
   logic [15:0] link_ff, link_in;
   logic [11:0] offs_ff, offs_in;

   assign csr_ready = 1'b1;

   always_comb begin
      base_in = base_ff;
      link_in = link_ff;
      offs_in = offs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_BASE_SPACING: base_in = csr_data;
            CSR_LINK_LENGTH:  link_in = csr_data;
            CSR_OFFSET_ANGLE: offs_in = csr_data[11:0];
            default: ;        // unknown index: dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         link_ff <= 16'd1600;
         offs_ff <= '0;
      end else begin
         base_ff <= base_in;
         link_ff <= link_in;
         offs_ff <= offs_in;
      end
   end

   // Derived config: (4L)^2 and the offset angle in Q format.
   // Each is registered after a write (d2_ff; aqn_ff then aq_ff) before a word reaches use.
   logic [2*SQ_W-1:0]       d2_ff, d2_in;
   logic [AQ_NW-1:0]        aqn_ff, aqn_in;
   logic [AQ_W-1:0]         aq_ff, aq_in;
   logic [AQ_N3W-1:0]       aqn3;
   logic [AQ_N3W+AQ_MW-1:0] aqp;

   assign d2_in  = (2*SQ_W)'({link_ff, 2'b00}) * (2*SQ_W)'({link_ff, 2'b00});
   assign aqn_in = AQ_NW'(offs_ff) * AQ_NW'(PI_Q30) + AQ_NW'(AQ_HALF);
   assign aqn3   = AQ_N3W'(aqn_ff >> (ASH + 6));
   assign aqp    = (AQ_N3W+AQ_MW)'(aqn3) * (AQ_N3W+AQ_MW)'(AQ_M);
   assign aq_in  = AQ_W'(aqp >> AQ_K);

   always_ff @(posedge clock) begin
      d2_ff  <= d2_in;
      aqn_ff <= aqn_in;
      aq_ff  <= aq_in;
   end

   // ---------------------------------------------------------------------
   // Pipe control: everything advances together unless the output stalls
   // ---------------------------------------------------------------------
   logic [NST-1:0] vld_ff, vld_in;
   logic           adv;

   assign adv       = !vld_ff[NST-1] || rsp_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: shift x toward the joint, take magnitudes
   // ---------------------------------------------------------------------
   logic signed [MAG_W:0]   x1;
   logic signed [MAG_W-1:0] y2;
   logic [MAG_W:0]          x1_abs;
   logic [MAG_W-1:0]        y2_abs;
   sq_side_type             s0_ff, s0_in;

   always_comb begin
      x1 = req_word.joint_side
         ? ($signed({req_word.target_x[15], req_word.target_x, 1'b0})
            - $signed({2'b00, base_ff}))
         : ($signed({req_word.target_x[15], req_word.target_x, 1'b0})
            + $signed({2'b00, base_ff}));
      y2     = $signed({req_word.target_y, 1'b0});
      x1_abs = x1[MAG_W] ? (MAG_W+1)'(-x1) : (MAG_W+1)'(x1);
      y2_abs = y2[MAG_W-1] ? MAG_W'(-y2) : MAG_W'(y2);
      s0_in.ax     = x1_abs[MAG_W-1:0];
      s0_in.ay     = y2_abs;
      s0_in.neg    = x1[MAG_W] ^ y2[MAG_W-1];
      s0_in.plus   = req_word.joint_side;
      s0_in.status = (x1 == '0 && y2 == '0) ? ST_POINT : ST_OK;
   end

   // ---------------------------------------------------------------------
   // Stage 1: r^2
   // ---------------------------------------------------------------------
   logic [SQ_RW-1:0] r2_ff, r2_in;
   sq_side_type      s1_ff;

   assign r2_in = SQ_RW'(s0_ff.ax) * SQ_RW'(s0_ff.ax)
                + SQ_RW'(s0_ff.ay) * SQ_RW'(s0_ff.ay);

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff <= s0_in;
         r2_ff <= r2_in;
         s1_ff <= s0_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Reach test, then two bitwise root chains: r = isqrt(r2),
   // h = isqrt(d2 - r2), one root bit per stage
   // ---------------------------------------------------------------------
   logic [SQ_RW-1:0] remr_ff [0:SQ_W];
   logic [SQ_RW-1:0] remr_in [0:SQ_W];
   logic [SQ_RW-1:0] remh_ff [0:SQ_W];
   logic [SQ_RW-1:0] remh_in [0:SQ_W];
   logic [SQ_W-1:0]  rtr_ff  [0:SQ_W];
   logic [SQ_W-1:0]  rtr_in  [0:SQ_W];
   logic [SQ_W-1:0]  rth_ff  [0:SQ_W];
   logic [SQ_W-1:0]  rth_in  [0:SQ_W];
   sq_side_type      sqs_ff  [0:SQ_W];
   sq_side_type      sqs_in  [0:SQ_W];
   sq_side_type      s1_chk;
   logic             far;

   assign far = r2_ff > SQ_RW'(d2_ff);

   always_comb begin
      s1_chk = s1_ff;
      if (s1_ff.status == ST_OK && far) begin
         s1_chk.status = ST_REACH;
      end
   end

   assign sqs_in[0]  = s1_chk;
   assign remr_in[0] = r2_ff;
   assign remh_in[0] = (s1_ff.status == ST_OK && !far) ? SQ_RW'(d2_ff) - r2_ff : '0;
   assign rtr_in[0]  = '0;
   assign rth_in[0]  = '0;

   for (genvar j = 0; j < SQ_W; j++) begin : g_sqrt
      localparam int B = SQ_W - 1 - j;
      logic [SQ_RW-1:0] tr, th;
      logic             ger, geh;

      assign tr  = (SQ_RW'(rtr_ff[j]) << (B + 1)) | (SQ_RW'(1) << (2 * B));
      assign th  = (SQ_RW'(rth_ff[j]) << (B + 1)) | (SQ_RW'(1) << (2 * B));
      assign ger = remr_ff[j] >= tr;
      assign geh = remh_ff[j] >= th;

      assign remr_in[j+1] = ger ? remr_ff[j] - tr : remr_ff[j];
      assign remh_in[j+1] = geh ? remh_ff[j] - th : remh_ff[j];
      assign rtr_in[j+1]  = ger ? (rtr_ff[j] | (SQ_W'(1) << B)) : rtr_ff[j];
      assign rth_in[j+1]  = geh ? (rth_ff[j] | (SQ_W'(1) << B)) : rth_ff[j];
      assign sqs_in[j+1]  = sqs_ff[j];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         remr_ff <= remr_in;
         remh_ff <= remh_in;
         rtr_ff  <= rtr_in;
         rth_ff  <= rth_in;
         sqs_ff  <= sqs_in;
      end
   end

   // ---------------------------------------------------------------------
   // Two vectoring CORDICs: w1 = atan2(|x1|, |y|), w2 = atan2(h, r)
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] ax_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] ax_in [0:CORDIC_STEPS];
   logic signed [CW-1:0] ay_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] ay_in [0:CORDIC_STEPS];
   logic signed [ZW-1:0] az_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0] az_in [0:CORDIC_STEPS];
   logic signed [CW-1:0] bx_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] bx_in [0:CORDIC_STEPS];
   logic signed [CW-1:0] by_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] by_in [0:CORDIC_STEPS];
   logic signed [ZW-1:0] bz_ff [0:CORDIC_STEPS];
   logic signed [ZW-1:0] bz_in [0:CORDIC_STEPS];
   cd_side_type          cds_ff [0:CORDIC_STEPS];
   cd_side_type          cds_in [0:CORDIC_STEPS];

   assign ax_in[0] = $signed(CW'(sqs_ff[SQ_W].ay) << CORDIC_PRESHIFT);
   assign ay_in[0] = $signed(CW'(sqs_ff[SQ_W].ax) << CORDIC_PRESHIFT);
   assign az_in[0] = '0;
   assign bx_in[0] = $signed(CW'(rtr_ff[SQ_W]) << CORDIC_PRESHIFT);
   assign by_in[0] = $signed(CW'(rth_ff[SQ_W]) << CORDIC_PRESHIFT);
   assign bz_in[0] = '0;
   assign cds_in[0].neg    = sqs_ff[SQ_W].neg;
   assign cds_in[0].plus   = sqs_ff[SQ_W].plus;
   assign cds_in[0].status = sqs_ff[SQ_W].status;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
      localparam logic signed [ZW-1:0] T = atan_q(k);
      logic pa, pb;

      assign pa = !ay_ff[k][CW-1];
      assign pb = !by_ff[k][CW-1];

      assign ax_in[k+1] = pa ? ax_ff[k] + (ay_ff[k] >>> k) : ax_ff[k] - (ay_ff[k] >>> k);
      assign ay_in[k+1] = pa ? ay_ff[k] - (ax_ff[k] >>> k) : ay_ff[k] + (ax_ff[k] >>> k);
      assign az_in[k+1] = pa ? az_ff[k] + T : az_ff[k] - T;
      assign bx_in[k+1] = pb ? bx_ff[k] + (by_ff[k] >>> k) : bx_ff[k] - (by_ff[k] >>> k);
      assign by_in[k+1] = pb ? by_ff[k] - (bx_ff[k] >>> k) : by_ff[k] + (bx_ff[k] >>> k);
      assign bz_in[k+1] = pb ? bz_ff[k] + T : bz_ff[k] - T;
      assign cds_in[k+1] = cds_ff[k];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         az_ff  <= az_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         bz_ff  <= bz_in;
         cds_ff <= cds_in;
      end
   end

   // ---------------------------------------------------------------------
   // Tail: joint angle + offset, |v|*2000 + pi/2, reciprocal, map and clamp
   // ---------------------------------------------------------------------
   logic signed [VW-1:0]     w1s, w2e, v_in, v_ff;
   logic [VW-1:0]            vabs;
   logic [DV_MW-1:0]         mag_ff, mag_in;
   logic [DV_MW+DV_MDW-1:0]  qprod;
   logic [QW-1:0]            q_ff, q_in;
   logic signed [PW-1:0]     qs, pulse;
   logic                     ta_neg_ff, tb_neg_ff;
   cd_side_type              ta_ff, tb_ff, tc_ff;
   rsp_word_type             out_ff, out_in;

   always_comb begin
      w1s  = cds_ff[CORDIC_STEPS].neg ? -VW'(az_ff[CORDIC_STEPS]) : VW'(az_ff[CORDIC_STEPS]);
      w2e  = VW'(bz_ff[CORDIC_STEPS]);
      v_in = (cds_ff[CORDIC_STEPS].plus ? w2e + w1s : w2e - w1s)
           + $signed(VW'(aq_ff));
   end

   assign vabs   = v_ff[VW-1] ? VW'(-v_ff) : VW'(v_ff);
   assign mag_in = DV_MW'(vabs) * DV_MW'(2000) + DV_MW'(HALF_PI_Q);
   assign qprod  = (DV_MW+DV_MDW)'(mag_ff) * (DV_MW+DV_MDW)'(DV_M);
   assign q_in   = QW'(qprod >> DV_K);

   always_comb begin
      qs    = tb_neg_ff ? -PW'(q_ff) : PW'(q_ff);
      pulse = tc_ff.plus ? PW'(500) + qs : PW'(2500) - qs;
      out_in.status = tc_ff.status;
      if (tc_ff.status != ST_OK || pulse < 0) begin
         out_in.pulse_us = '0;
      end else if (pulse > PW'(PULSE_MAX)) begin
         out_in.pulse_us = PULSE_W'(PULSE_MAX);
      end else begin
         out_in.pulse_us = PULSE_W'(pulse);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff      <= v_in;
         ta_ff     <= cds_ff[CORDIC_STEPS];
         mag_ff    <= mag_in;
         ta_neg_ff <= v_ff[VW-1];
         tb_ff     <= ta_ff;
         q_ff      <= q_in;
         tb_neg_ff <= ta_neg_ff;
         tc_ff     <= tb_ff;
         out_ff    <= out_in;
      end
   end

   assign rsp_valid = vld_ff[NST-1];
   assign rsp_word  = out_ff;

endmodule

/* hw/rtl/fbas_checker.sv */
// ----------------------------------------------------------------------------
// fbas_checker
// Port-level checks for the five-bar servo pulse core, bound to the top.
// ----------------------------------------------------------------------------
`include "five_bar_arm_servo_pulse_core_assert.svh"

module fbas_checker
   import fbas_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_word_type          req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_word_type          rsp_word,
   input logic                  csr_valid,
   input logic                  csr_ready,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_data
);

   `FBAS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "rsp word dropped or changed while stalled")
   `FBAS_ASSERT_NOW(a_err_zero, rsp_valid && rsp_word.status != ST_OK, rsp_word.pulse_us == '0, "error word carries a pulse")
   `FBAS_ASSERT_NOW(a_status_code, rsp_valid, rsp_word.status == ST_OK || rsp_word.status == ST_REACH || rsp_word.status == ST_POINT, "bad status code")
   `FBAS_ASSERT_NOW(a_ready_free, !rsp_valid, req_ready, "input blocked with empty output")
   `FBAS_ASSERT_ALWAYS(a_reset_quiet, reset, !rsp_valid, "rsp valid right after reset")

endmodule

bind five_bar_arm_servo_pulse_core fbas_checker u_fbas_checker (.*);
